// ===== sv/brp_pkg.sv =====
// ---------------------------------------------------------------------------
// brp_pkg
// Shared types, codes and helpers for the bounded rank pool.
// ---------------------------------------------------------------------------
package brp_pkg;

   localparam int POOL_DEPTH = 64;
   localparam int IDX_W      = $clog2(POOL_DEPTH);
   localparam int CNT_W      = $clog2(POOL_DEPTH + 1);
   localparam int BAD_W      = 7;
   localparam int REC_W      = 64 * 6 + 32;

   // register indexes
   localparam logic [2:0] CSR_SELF_PREFIX = 3'd0;
   localparam logic [2:0] CSR_SELF_KEY_W0 = 3'd1;
   localparam logic [2:0] CSR_SELF_KEY_W1 = 3'd2;
   localparam logic [2:0] CSR_SELF_KEY_W2 = 3'd3;
   localparam logic [2:0] CSR_SELF_KEY_W3 = 3'd4;
   localparam logic [2:0] CSR_POOL_LIMIT  = 3'd5;

   // result codes
   localparam logic [2:0] ST_ADDED = 3'd0;
   localparam logic [2:0] ST_DUP   = 3'd1;
   localparam logic [2:0] ST_SELF  = 3'd2;
   localparam logic [2:0] ST_GIVEN = 3'd3;
   localparam logic [2:0] ST_EMPTY = 3'd4;

   localparam logic FUNC_ADD = 1'b0;

   typedef struct packed {
      logic [63:0] key_w0;
      logic [63:0] key_w1;
      logic [63:0] key_w2;
      logic [63:0] key_w3;
      logic [63:0] route;
      logic [63:0] prefix;
      logic [31:0] version;
   } rec_type;

   // highest set bit, zero for zero
   function automatic logic [5:0] flog2(input logic [63:0] v);
      logic [5:0] n;
      n = '0;
      for (int i = 1; i < 64; i++) begin
         if (v[i]) n = i[5:0];
      end
      return n;
   endfunction

endpackage

// ===== sv/brp_store.sv =====
// ---------------------------------------------------------------------------
// brp_store
// Record memory, one write and one registered read port.
// ---------------------------------------------------------------------------
module brp_store (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [brp_pkg::IDX_W-1:0] wr_addr,
   input  brp_pkg::rec_type     wr_data,
   input  logic [brp_pkg::IDX_W-1:0] rd_addr,
   output brp_pkg::rec_type     rd_data
);
   import brp_pkg::*;

   rec_type mem [POOL_DEPTH];
   rec_type rd_ff;

   // write port and registered read
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_ff <= mem[rd_addr];
   end

   assign rd_data = rd_ff;

endmodule

// ===== sv/bounded_rank_pool_evict_worst_unit.sv =====
// ---------------------------------------------------------------------------
// bounded_rank_pool_evict_worst_unit
// Bounded pool of node records with worst-rank eviction and best-rank get.
// ---------------------------------------------------------------------------
// One command at a time. Every command first scans the stored records, one
// memory read per record, so the time grows with the fill level (count).
// After the scan, an add decides and writes in S_DEC, a get on an empty pool
// ends there, and a get that gives a record goes on to re-read the chosen
// entry, then read and move the last entry into its slot. The record memory
// with its single registered read port sets the rate of one record per
// cycle. busy is high from the accepting edge through the result beat, so
// the next command can be taken in the cycle after the result. The result
// is shown for one cycle on rsp_valid and cannot be held off.
module bounded_rank_pool_evict_worst_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata,
   input  logic        start,
   output logic        busy,
   input  logic        req_func,
   input  logic [63:0] req_in_key_w0,
   input  logic [63:0] req_in_key_w1,
   input  logic [63:0] req_in_key_w2,
   input  logic [63:0] req_in_key_w3,
   input  logic [63:0] req_in_route,
   input  logic [63:0] req_in_prefix,
   input  logic [31:0] req_in_version,
   output logic        rsp_valid,
   output logic [2:0]  rsp_status,
   output logic [63:0] rsp_out_key_w0,
   output logic [63:0] rsp_out_key_w1,
   output logic [63:0] rsp_out_key_w2,
   output logic [63:0] rsp_out_key_w3,
   output logic [63:0] rsp_out_route,
   output logic [63:0] rsp_out_prefix,
   output logic [31:0] rsp_out_version,
   output logic [6:0]  rsp_fill_level
);
   import brp_pkg::*;

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_SCAN  = 7'b0000010,
      S_DEC   = 7'b0000100,
      S_GRD   = 7'b0001000,
      S_LRD   = 7'b0010000,
      S_MOVE  = 7'b0100000,
      S_DONE  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   logic [63:0] self_prefix_ff, sk0_ff, sk1_ff, sk2_ff, sk3_ff;
   logic [6:0]  limit_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   logic        func_ff;
   rec_type     req_ff;
   logic [CNT_W-1:0] rd_idx_ff, rd_idx_in;   // address issued
   logic [CNT_W-1:0] cmp_idx_ff, cmp_idx_in; // address of data on port
   logic        cmp_vld_ff, cmp_vld_in;
   logic        dup_ff, dup_in;
   logic [BAD_W-1:0] best_ff, best_in;
   logic [IDX_W-1:0] slot_ff, slot_in;
   rec_type     given_ff, given_in;
   logic [2:0]  status_ff, status_in;
   logic        rsp_ff;

   logic        wr_en;
   logic [IDX_W-1:0] wr_addr, rd_addr;
   rec_type     wr_data, rd_data;
   logic [BAD_W-1:0] bad;
   logic [CNT_W-1:0] cap;
   logic        self_hit;

   brp_store u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // badness of the entry on the read port
   assign bad = BAD_W'(flog2(rd_data.prefix ^ self_prefix_ff))
              + BAD_W'(flog2(rd_data.route));

   // capacity clamp
   always_comb begin
      if (limit_ff == 7'd0) cap = CNT_W'(1);
      else if (CNT_W'(limit_ff) > CNT_W'(POOL_DEPTH)) cap = CNT_W'(POOL_DEPTH);
      else cap = CNT_W'(limit_ff);
   end

   assign self_hit = (req_ff.key_w0 == sk0_ff) && (req_ff.key_w1 == sk1_ff)
                  && (req_ff.key_w2 == sk2_ff) && (req_ff.key_w3 == sk3_ff);

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         self_prefix_ff <= '0;
         sk0_ff <= '0; sk1_ff <= '0; sk2_ff <= '0; sk3_ff <= '0;
         limit_ff <= 7'd64;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SELF_PREFIX: self_prefix_ff <= csr_wdata;
            CSR_SELF_KEY_W0: sk0_ff <= csr_wdata;
            CSR_SELF_KEY_W1: sk1_ff <= csr_wdata;
            CSR_SELF_KEY_W2: sk2_ff <= csr_wdata;
            CSR_SELF_KEY_W3: sk3_ff <= csr_wdata;
            CSR_POOL_LIMIT:  limit_ff <= csr_wdata[6:0];
            default: ;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      rd_idx_in  = rd_idx_ff;
      cmp_idx_in = rd_idx_ff;
      cmp_vld_in = 1'b0;
      dup_in     = dup_ff;
      best_in    = best_ff;
      slot_in    = slot_ff;
      given_in   = given_ff;
      status_in  = status_ff;
      wr_en      = 1'b0;
      wr_addr    = slot_ff;
      wr_data    = req_ff;
      rd_addr    = rd_idx_ff[IDX_W-1:0];
      unique case (state_ff)
         S_IDLE: begin
            rd_addr = '0;
            if (start && !busy) begin
               rd_idx_in = '0;
               dup_in    = 1'b0;
               best_in   = '0;
               slot_in   = '0;
               given_in  = '0;
               state_in  = S_SCAN;
            end
         end
         S_SCAN: begin
            // compare entry from last cycle, issue next address
            if (cmp_vld_ff) begin
               if (func_ff == FUNC_ADD) begin
                  if (rd_data.route == req_ff.route && rd_data.key_w0 == req_ff.key_w0
                      && rd_data.key_w1 == req_ff.key_w1
                      && rd_data.key_w2 == req_ff.key_w2
                      && rd_data.key_w3 == req_ff.key_w3)
                     dup_in = 1'b1;
                  if (bad > best_ff) begin
                     best_in = bad;
                     slot_in = cmp_idx_ff[IDX_W-1:0];
                  end
               end else if (cmp_idx_ff == '0 || bad < best_ff) begin
                  best_in = bad;
                  slot_in = cmp_idx_ff[IDX_W-1:0];
               end
            end
            if (rd_idx_ff < count_ff) begin
               cmp_vld_in = 1'b1;
               rd_idx_in  = rd_idx_ff + CNT_W'(1);
            end else if (!cmp_vld_ff) begin
               state_in = S_DEC;
            end
         end
         S_DEC: begin
            if (func_ff == FUNC_ADD) begin
               if (dup_ff) status_in = ST_DUP;
               else if (self_hit) status_in = ST_SELF;
               else begin
                  status_in = ST_ADDED;
                  wr_en = 1'b1;
                  if (count_ff < cap) begin
                     wr_addr  = count_ff[IDX_W-1:0];
                     count_in = count_ff + CNT_W'(1);
                  end
               end
               state_in = S_DONE;
            end else if (count_ff == '0) begin
               status_in = ST_EMPTY;
               state_in  = S_DONE;
            end else begin
               status_in = ST_GIVEN;
               rd_addr   = slot_ff;
               state_in  = S_GRD;
            end
         end
         S_GRD: begin
            // chosen entry is on the read port, capture it; fetch last entry
            count_in = count_ff - CNT_W'(1);
            rd_addr  = count_in[IDX_W-1:0];
            given_in = rd_data;
            state_in = S_LRD;
         end
         S_LRD: begin
            // keep the last entry on the read port for the move
            rd_addr  = count_ff[IDX_W-1:0];
            state_in = S_MOVE;
         end
         S_MOVE: begin
            wr_en    = (count_ff[IDX_W-1:0] != slot_ff) || (count_ff == CNT_W'(POOL_DEPTH));
            wr_addr  = slot_ff;
            wr_data  = rd_data;
            state_in = S_DONE;
         end
         S_DONE: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         count_ff   <= '0;
         cmp_vld_ff <= 1'b0;
         rsp_ff     <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         cmp_vld_ff <= cmp_vld_in;
         rsp_ff     <= (state_ff == S_DONE);
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && start && !rsp_ff) begin
         func_ff <= req_func;
         req_ff  <= '{req_in_key_w0, req_in_key_w1, req_in_key_w2, req_in_key_w3,
                      req_in_route, req_in_prefix, req_in_version};
      end
      rd_idx_ff  <= rd_idx_in;
      cmp_idx_ff <= cmp_idx_in;
      dup_ff     <= dup_in;
      best_ff    <= best_in;
      slot_ff    <= slot_in;
      given_ff   <= given_in;
      status_ff  <= status_in;
   end

   assign busy            = (state_ff != S_IDLE) || rsp_ff;
   assign rsp_valid       = rsp_ff;
   assign rsp_status      = status_ff;
   assign rsp_out_key_w0  = given_ff.key_w0;
   assign rsp_out_key_w1  = given_ff.key_w1;
   assign rsp_out_key_w2  = given_ff.key_w2;
   assign rsp_out_key_w3  = given_ff.key_w3;
   assign rsp_out_route   = given_ff.route;
   assign rsp_out_prefix  = given_ff.prefix;
   assign rsp_out_version = given_ff.version;
   assign rsp_fill_level  = 7'(count_ff);

`ifndef ASSERT_OFF
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(POOL_DEPTH)) else $error("count overflow");
   a_rsp_after_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == S_DONE)) else $error("stray response");
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_EMPTY) |-> rsp_fill_level == 7'd0)
      else $error("empty with records");
   a_get_dec: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_GRD |=> count_ff == $past(count_ff) - CNT_W'(1))
      else $error("get count");
`endif

endmodule

// ===== tb/sv/bounded_rank_pool_evict_worst_unit_tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// bounded_rank_pool_evict_worst_unit_tb
// Self-checking bench for the bounded rank pool. A driver sends add and get
// beats from a queue, a monitor compares each result beat against a local
// pool model, and the pool settings are changed between phases.
// ---------------------------------------------------------------------------
module bounded_rank_pool_evict_worst_unit_tb;
   import brp_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct {
      logic        func;
      rec_type     rec;
   } cmd_type;

   typedef struct {
      logic [2:0]  status;
      rec_type     rec;
      logic [6:0]  fill;
   } reply_type;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [63:0] csr_wdata;
   logic        start;
   logic        busy;
   logic        req_func;
   logic [63:0] req_in_key_w0, req_in_key_w1, req_in_key_w2, req_in_key_w3;
   logic [63:0] req_in_route, req_in_prefix;
   logic [31:0] req_in_version;
   logic        rsp_valid;
   logic [2:0]  rsp_status;
   logic [63:0] rsp_out_key_w0, rsp_out_key_w1, rsp_out_key_w2, rsp_out_key_w3;
   logic [63:0] rsp_out_route, rsp_out_prefix;
   logic [31:0] rsp_out_version;
   logic [6:0]  rsp_fill_level;

   bounded_rank_pool_evict_worst_unit uut (.*);

   // model state
   rec_type     pool_rec [POOL_DEPTH];
   int          pool_count;
   logic [63:0] own_prefix;
   logic [255:0] own_key;
   logic [6:0]  limit_reg;

   cmd_type     cmd_queue [$];
   reply_type   reply_queue [$];
   int          error_count;
   int          beats_sent;
   int          replies_seen;
   int          gets_given;
   int          evictions;
   int          idle_cycles;
   int          gap_left;
   bit          stim_done;

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int rank_of(rec_type r);
      int hi_x, hi_r;
      logic [63:0] x;
      x = r.prefix ^ own_prefix;
      hi_x = 0;
      hi_r = 0;
      for (int i = 1; i < 64; i++) begin
         if (x[i]) hi_x = i;
         if (r.route[i]) hi_r = i;
      end
      return hi_x + hi_r;
   endfunction

   // pool model: apply one command, return the reply
   function automatic reply_type pool_apply(cmd_type c);
      reply_type rp;
      int cap, slot, worst, best, b;
      rp.status = ST_ADDED;
      rp.rec = '0;
      cap = (limit_reg < 1) ? 1 : ((limit_reg > POOL_DEPTH) ? POOL_DEPTH : int'(limit_reg));
      if (c.func == FUNC_ADD) begin
         for (int i = 0; i < pool_count; i++) begin
            if (pool_rec[i].route == c.rec.route && pool_rec[i].key_w0 == c.rec.key_w0 &&
                pool_rec[i].key_w1 == c.rec.key_w1 && pool_rec[i].key_w2 == c.rec.key_w2 &&
                pool_rec[i].key_w3 == c.rec.key_w3) begin
               rp.status = ST_DUP;
               break;
            end
         end
         if (rp.status == ST_ADDED &&
             {c.rec.key_w0, c.rec.key_w1, c.rec.key_w2, c.rec.key_w3} == own_key)
            rp.status = ST_SELF;
         if (rp.status == ST_ADDED) begin
            if (pool_count < cap) begin
               slot = pool_count;
               pool_count++;
            end else begin
               worst = 0;
               slot = 0;
               for (int i = 0; i < pool_count; i++) begin
                  b = rank_of(pool_rec[i]);
                  if (b > worst) begin
                     worst = b;
                     slot = i;
                  end
               end
               evictions++;
            end
            pool_rec[slot] = c.rec;
         end
      end else if (pool_count == 0) begin
         rp.status = ST_EMPTY;
      end else begin
         best = rank_of(pool_rec[0]);
         slot = 0;
         for (int i = 1; i < pool_count; i++) begin
            b = rank_of(pool_rec[i]);
            if (b < best) begin
               best = b;
               slot = i;
            end
         end
         rp.status = ST_GIVEN;
         rp.rec = pool_rec[slot];
         pool_count--;
         pool_rec[slot] = pool_rec[pool_count];
         gets_given++;
      end
      rp.fill = pool_count[6:0];
      return rp;
   endfunction

   // random record; small pools of keys and routes so duplicates happen
   function automatic rec_type rand_rec();
      rec_type r;
      r.key_w0 = {$urandom, $urandom};
      r.key_w1 = {$urandom, $urandom};
      r.key_w2 = {$urandom, $urandom};
      r.key_w3 = {$urandom, $urandom};
      if ($urandom_range(0, 2) == 0) begin
         r.key_w0 = 64'($urandom_range(0, 3));
         r.key_w1 = '0;
         r.key_w2 = '0;
         r.key_w3 = 64'($urandom_range(0, 3));
      end
      case ($urandom_range(0, 3))
         0: r.route = 64'($urandom_range(0, 3));
         1: r.route = 64'd1 << $urandom_range(0, 63);
         default: r.route = {$urandom, $urandom};
      endcase
      case ($urandom_range(0, 3))
         0: r.prefix = own_prefix;
         1: r.prefix = own_prefix ^ (64'd1 << $urandom_range(0, 63));
         default: r.prefix = {$urandom, $urandom};
      endcase
      r.version = $urandom;
      return r;
   endfunction

   task automatic push_cmd(logic f, rec_type r);
      cmd_type c;
      c.func = f;
      c.rec = r;
      cmd_queue.push_back(c);
   endtask

   // register write at the falling edge, model updated alongside
   task automatic write_csr(logic [2:0] idx, logic [63:0] val);
      @(negedge clock);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      case (idx)
         CSR_SELF_PREFIX: own_prefix = val;
         CSR_SELF_KEY_W0: own_key[255:192] = val;
         CSR_SELF_KEY_W1: own_key[191:128] = val;
         CSR_SELF_KEY_W2: own_key[127:64] = val;
         CSR_SELF_KEY_W3: own_key[63:0] = val;
         CSR_POOL_LIMIT:  limit_reg = val[6:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic drain();
      wait (cmd_queue.size() == 0 && reply_queue.size() == 0 && !busy);
      repeat (8) @(negedge clock);
   endtask

   // driver
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
         gap_left <= 0;
      end else if (start) begin
         // beat taken at the last rising edge
         start <= 1'b0;
         gap_left <= $urandom_range(0, 6);
      end else if (!busy && cmd_queue.size() != 0) begin
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
         end else begin
            cmd_type c;
            c = cmd_queue.pop_front();
            reply_queue.push_back(pool_apply(c));
            req_func <= c.func;
            req_in_key_w0 <= c.rec.key_w0;
            req_in_key_w1 <= c.rec.key_w1;
            req_in_key_w2 <= c.rec.key_w2;
            req_in_key_w3 <= c.rec.key_w3;
            req_in_route <= c.rec.route;
            req_in_prefix <= c.rec.prefix;
            req_in_version <= c.rec.version;
            start <= 1'b1;
            beats_sent++;
         end
      end
   end

   // monitor and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if ((start && !busy) || rsp_valid) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles > WATCHDOG_LIMIT && (cmd_queue.size() != 0 ||
             reply_queue.size() != 0)) begin
            $display("watchdog: no beat for %0d cycles", idle_cycles);
            $display("Some tests failed");
            $finish;
         end
         if (rsp_valid) begin
            replies_seen++;
            if (reply_queue.size() == 0) begin
               $error("result beat with nothing expected");
               error_count++;
            end else begin
               reply_type e;
               e = reply_queue.pop_front();
               if (rsp_status !== e.status) begin
                  $error("status exp %0d got %0d", e.status, rsp_status); error_count++;
               end
               if (rsp_out_key_w0 !== e.rec.key_w0) begin
                  $error("out_key_w0 exp %h got %h", e.rec.key_w0, rsp_out_key_w0);
                  error_count++;
               end
               if (rsp_out_key_w1 !== e.rec.key_w1) begin
                  $error("out_key_w1 exp %h got %h", e.rec.key_w1, rsp_out_key_w1);
                  error_count++;
               end
               if (rsp_out_key_w2 !== e.rec.key_w2) begin
                  $error("out_key_w2 exp %h got %h", e.rec.key_w2, rsp_out_key_w2);
                  error_count++;
               end
               if (rsp_out_key_w3 !== e.rec.key_w3) begin
                  $error("out_key_w3 exp %h got %h", e.rec.key_w3, rsp_out_key_w3);
                  error_count++;
               end
               if (rsp_out_route !== e.rec.route) begin
                  $error("out_route exp %h got %h", e.rec.route, rsp_out_route);
                  error_count++;
               end
               if (rsp_out_prefix !== e.rec.prefix) begin
                  $error("out_prefix exp %h got %h", e.rec.prefix, rsp_out_prefix);
                  error_count++;
               end
               if (rsp_out_version !== e.rec.version) begin
                  $error("out_version exp %h got %h", e.rec.version, rsp_out_version);
                  error_count++;
               end
               if (rsp_fill_level !== e.fill) begin
                  $error("fill_level exp %0d got %0d", e.fill, rsp_fill_level);
                  error_count++;
               end
            end
         end
      end
   end

   // stimulus
   initial begin
      rec_type r;
      logic [6:0] limits [6];
      int n;
      limits = '{7'd64, 7'd1, 7'd4, 7'd0, 7'd100, 7'd127};
      reset = 1'b1;
      csr_we = 1'b0; csr_index = '0; csr_wdata = '0;
      start = 1'b0; req_func = 1'b0;
      req_in_key_w0 = '0; req_in_key_w1 = '0; req_in_key_w2 = '0; req_in_key_w3 = '0;
      req_in_route = '0; req_in_prefix = '0; req_in_version = '0;
      own_prefix = '0; own_key = '0; limit_reg = 7'd64;
      pool_count = 0; error_count = 0; beats_sent = 0; replies_seen = 0;
      gets_given = 0; evictions = 0; idle_cycles = 0; stim_done = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: empty get, self key (zero), extremes, duplicate
      write_csr(CSR_POOL_LIMIT, 64'd3);
      push_cmd(1'b1, '0);
      r = '0; r.route = 64'd5; push_cmd(FUNC_ADD, r);          // equals own key, dropped
      r = '1; push_cmd(FUNC_ADD, r);
      push_cmd(FUNC_ADD, r);                                   // duplicate
      r.route = 64'd0; r.version = 32'd0; push_cmd(FUNC_ADD, r);
      r = '0; r.key_w3 = 64'd1; r.version = 32'd1; push_cmd(FUNC_ADD, r);
      r.key_w3 = 64'd2; r.prefix = '1; r.route = 64'h8000_0000_0000_0000;
      push_cmd(FUNC_ADD, r);                                   // full, evicts worst
      for (int i = 0; i < 4; i++) push_cmd(1'b1, '0);
      // all ranks zero when full: entry 0 replaced
      for (int i = 0; i < 4; i++) begin
         r = '0; r.key_w0 = 64'(i + 10); r.route = 64'd1; r.version = 32'(i);
         push_cmd(FUNC_ADD, r);
      end
      for (int i = 0; i < 4; i++) push_cmd(1'b1, '0);
      drain();

      // random phases over several settings
      for (int p = 0; p < 12; p++) begin
         write_csr(CSR_SELF_PREFIX, (p % 3 == 0) ? 64'd0 : ((p % 3 == 1) ? '1 : {$urandom, $urandom}));
         write_csr(CSR_SELF_KEY_W0, (p % 2) ? 64'd0 : {$urandom, $urandom});
         write_csr(CSR_SELF_KEY_W1, (p % 2) ? 64'd0 : '1);
         write_csr(CSR_SELF_KEY_W2, (p % 2) ? 64'd0 : {$urandom, $urandom});
         write_csr(CSR_SELF_KEY_W3, (p % 2) ? 64'd1 : {$urandom, $urandom});
         write_csr(CSR_POOL_LIMIT, (p < 6) ? 64'(limits[p]) : 64'($urandom_range(1, 64)));
         n = 150;
         for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 19) == 0) begin
               r = '0;
               r.key_w0 = own_key[255:192]; r.key_w1 = own_key[191:128];
               r.key_w2 = own_key[127:64]; r.key_w3 = own_key[63:0];
               r.route = {$urandom, $urandom}; r.version = $urandom;
               push_cmd(FUNC_ADD, r);
            end else begin
               push_cmd(($urandom_range(0, 9) < ((i / 40) % 2 ? 6 : 3)), rand_rec());
            end
         end
         // lower the limit mid-stream only between phases: drain first
         drain();
      end
      stim_done = 1;
      repeat (100) @(negedge clock);

      $display("sent %0d beats, %0d results, %0d records given, %0d evictions",
               beats_sent, replies_seen, gets_given, evictions);
      if (error_count == 0 && reply_queue.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
